### sv/ptrf_pkg.sv
// ---------------------------------------------------------------------------
// ptrf_pkg
// Shared constants, types and the highlight table of the page-turn row fold.
// ---------------------------------------------------------------------------
package ptrf_pkg;

	// line store geometry: two banks of one row each, bank in the top address bit
	localparam int MAX_WIDTH   = 2048;
	localparam int BAND_WIDTH  = 24;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int STORE_DEPTH = 2 * MAX_WIDTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int PIX_W       = 24;

	// register widths
	localparam int FW_W   = 12;
	localparam int CUT_W  = 12;
	localparam int STEP_W = 23;
	localparam int CFG_W  = 23;

	// shade arithmetic, unsigned q0.24
	localparam int          SHADE_W    = 24;
	localparam int          DROP_W     = COL_W + STEP_W;
	localparam logic [23:0] SHADE_BASE = 24'd8724152;

	// register reset values
	localparam logic [FW_W-1:0]   FW_RESET   = 12'd640;
	localparam logic [CUT_W-1:0]  CUT_RESET  = 12'd2048;
	localparam logic [STEP_W-1:0] STEP_RESET = 23'd0;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH = 2'd0,
		CFG_CUT_COLUMN  = 2'd1,
		CFG_SHADE_STEP  = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_SHADE,
		ST_RESULT
	} ptrf_state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic issue;
		logic shade;
		logic load;
	} ptrf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_range;
		logic prev_ready;
	} ptrf_stat_t;

	// floor(75*sin(i*pi/30)) over the highlight band
	function automatic logic [7:0] glow_value(input logic [4:0] idx);
		logic [7:0] v;
		unique case (idx)
			5'd0:  v = 8'd0;
			5'd1:  v = 8'd7;
			5'd2:  v = 8'd15;
			5'd3:  v = 8'd23;
			5'd4:  v = 8'd30;
			5'd5:  v = 8'd37;
			5'd6:  v = 8'd44;
			5'd7:  v = 8'd50;
			5'd8:  v = 8'd55;
			5'd9:  v = 8'd60;
			5'd10: v = 8'd64;
			5'd11: v = 8'd68;
			5'd12: v = 8'd71;
			5'd13: v = 8'd73;
			5'd14: v = 8'd74;
			5'd15: v = 8'd75;
			5'd16: v = 8'd74;
			5'd17: v = 8'd73;
			5'd18: v = 8'd71;
			5'd19: v = 8'd68;
			5'd20: v = 8'd64;
			5'd21: v = 8'd60;
			5'd22: v = 8'd55;
			5'd23: v = 8'd50;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

### sv/ptrf_if.sv
// ---------------------------------------------------------------------------
// ptrf_pixel_if / ptrf_result_if
// Valid/ready channels for incoming pixels and processed pixels.
// ---------------------------------------------------------------------------
interface ptrf_pixel_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;
	logic [10:0] column;
	logic        flush;

	modport source(output valid, red_in, green_in, blue_in, column, flush, input ready);
	modport sink(input valid, red_in, green_in, blue_in, column, flush, output ready);
endinterface

interface ptrf_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic [10:0] out_column;

	modport source(output valid, red_out, green_out, blue_out, out_column, input ready);
	modport sink(input valid, red_out, green_out, blue_out, out_column, output ready);
endinterface

### sv/page_turn_row_fold_core.sv
// Pixels are handled one at a time: an accepted pixel passes the issue state, then the shade
// and result states when it yields a result; the result state waits for a free output register.
// The order is set by the line store's registered read followed by the shade and product steps.
// Reset: config registers return to width 640, cut 2048, step 0; bank and previous-row
// flag clear; the line store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// page_turn_row_fold_core
// Page-turn fold on an rgb raster stream with one row of delay.
// ---------------------------------------------------------------------------
module page_turn_row_fold_core import ptrf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	ptrf_pixel_if.sink       pixel_stream,
	ptrf_result_if.source    result_stream,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	ptrf_cmd_t  cmd;
	ptrf_stat_t stat;

	// transaction sequencer
	ptrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel_stream.valid),
		.in_ready (pixel_stream.ready),
		.out_valid(result_stream.valid),
		.out_ready(result_stream.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// pixel datapath
	ptrf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.red_in    (pixel_stream.red_in),
		.green_in  (pixel_stream.green_in),
		.blue_in   (pixel_stream.blue_in),
		.column    (pixel_stream.column),
		.flush     (pixel_stream.flush),
		.cmd       (cmd),
		.stat      (stat),
		.red_out   (result_stream.red_out),
		.green_out (result_stream.green_out),
		.blue_out  (result_stream.blue_out),
		.out_column(result_stream.out_column)
	);

endmodule

### sv/ptrf_ram.sv
// ---------------------------------------------------------------------------
// ptrf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ptrf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/ptrf_ctrl.sv
// ---------------------------------------------------------------------------
// ptrf_ctrl
// Sequencer of one pixel transaction: issue, shade, result, plus output valid.
// ---------------------------------------------------------------------------
module ptrf_ctrl import ptrf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  ptrf_stat_t stat,
	output ptrf_cmd_t  cmd
);

	ptrf_state_t state_q, state_d;
	logic        out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (stat.in_range && stat.prev_ready) begin
					state_d = ST_SHADE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SHADE: begin
				cmd.shade = 1'b1;
				state_d   = ST_RESULT;
			end
			ST_RESULT: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### sv/ptrf_datapath.sv
// ---------------------------------------------------------------------------
// ptrf_datapath
// Config registers, ping-pong line store, fold address, shade and highlight.
// ---------------------------------------------------------------------------
module ptrf_datapath import ptrf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [7:0]       red_in,
	input  logic [7:0]       green_in,
	input  logic [7:0]       blue_in,
	input  logic [10:0]      column,
	input  logic             flush,
	input  ptrf_cmd_t        cmd,
	output ptrf_stat_t       stat,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out,
	output logic [10:0]      out_column
);

	logic [FW_W-1:0]   frame_width_q;
	logic [CUT_W-1:0]  cut_column_q;
	logic [STEP_W-1:0] shade_step_q;
	logic              bank_q;
	logic              prev_ready_q;

	logic [7:0]        red_q, green_q, blue_q;
	logic [COL_W-1:0]  col_q;
	logic              flush_q;

	logic              fold_s1;
	logic [7:0]        glow_s1;
	logic [DROP_W-1:0] drop_s1;
	logic [COL_W-1:0]  col_s1;
	logic [SHADE_W-1:0] shade_s2;
	logic [PIX_W-1:0]  px_s2;
	logic [PIX_W-1:0]  rdata;

	logic [FW_W-1:0]   width_used;
	logic [FW_W-1:0]   col_ext;
	logic              in_range;
	logic              cut_ok;
	logic              fold;
	logic [FW_W-1:0]   k_ext;
	logic [FW_W-1:0]   src_ext;
	logic              row_last;
	logic [FW_W:0]     band_pos;
	logic              band;
	logic [COL_W-1:0]  rd_col;
	logic              wr_en;
	logic              rd_en;

	logic [7:0]        ch_in [3];
	logic [7:0]        ch_out [3];
	logic [31:0]       prod [3];
	logic [8:0]        sum [3];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FW_RESET;
			cut_column_q  <= CUT_RESET;
			shade_step_q  <= STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH: frame_width_q <= cfg_data[FW_W-1:0];
				CFG_CUT_COLUMN:  cut_column_q  <= cfg_data[CUT_W-1:0];
				CFG_SHADE_STEP:  shade_step_q  <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// input transaction capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			red_q   <= red_in;
			green_q <= green_in;
			blue_q  <= blue_in;
			col_q   <= column;
			flush_q <= flush;
		end
	end

	// region decode on the captured column
	always_comb begin
		if (frame_width_q == '0) begin
			width_used = FW_W'(1);
		end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
			width_used = FW_W'(MAX_WIDTH);
		end else begin
			width_used = frame_width_q;
		end
		col_ext  = {1'b0, col_q};
		in_range = col_ext < width_used;
		cut_ok   = cut_column_q < width_used;
		fold     = cut_ok && (col_ext >= cut_column_q);
		k_ext    = col_ext - cut_column_q;
		src_ext  = width_used - FW_W'(1) - k_ext;
		row_last = col_ext == (width_used - FW_W'(1));
		band_pos = {1'b0, col_ext} + (FW_W+1)'(BAND_WIDTH) - {1'b0, cut_column_q};
		band     = cut_ok && !fold
			&& (({1'b0, col_ext} + (FW_W+1)'(BAND_WIDTH)) >= {1'b0, cut_column_q});
		rd_col   = fold ? src_ext[COL_W-1:0] : col_q;
		wr_en    = cmd.issue && in_range && !flush_q;
		rd_en    = cmd.issue && in_range && prev_ready_q;
	end

	assign stat.in_range   = in_range;
	assign stat.prev_ready = prev_ready_q;

	// bank toggle and previous-row flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q       <= 1'b0;
			prev_ready_q <= 1'b0;
		end else if (cmd.issue && in_range && row_last) begin
			if (flush_q) begin
				prev_ready_q <= 1'b0;
			end else begin
				bank_q       <= ~bank_q;
				prev_ready_q <= 1'b1;
			end
		end
	end

	// line store: write the current bank, read the other one
	ptrf_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr({bank_q, col_q}),
		.wdata({red_q, green_q, blue_q}),
		.re   (rd_en),
		.raddr({~bank_q, rd_col}),
		.rdata(rdata)
	);

	// stage 1: region flags and shade drop
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			fold_s1 <= fold;
			glow_s1 <= band ? glow_value(band_pos[4:0]) : 8'd0;
			drop_s1 <= DROP_W'(k_ext[COL_W-1:0]) * DROP_W'(shade_step_q);
			col_s1  <= col_q;
		end
	end

	// stage 2: shade saturating at zero, store word captured
	always_ff @(posedge clk) begin
		if (cmd.shade) begin
			shade_s2 <= (drop_s1 >= DROP_W'(SHADE_BASE))
				? '0 : SHADE_BASE - drop_s1[SHADE_W-1:0];
			px_s2    <= rdata;
		end
	end

	// per-channel shade product or saturating highlight
	assign ch_in[0] = px_s2[23:16];
	assign ch_in[1] = px_s2[15:8];
	assign ch_in[2] = px_s2[7:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = 32'(ch_in[i]) * 32'(shade_s2);
			sum[i]  = {1'b0, ch_in[i]} + {1'b0, glow_s1};
			if (fold_s1) begin
				ch_out[i] = prod[i][31:24];
			end else begin
				ch_out[i] = sum[i][8] ? 8'hFF : sum[i][7:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			red_out    <= ch_out[0];
			green_out  <= ch_out[1];
			blue_out   <= ch_out[2];
			out_column <= col_s1;
		end
	end

endmodule

### sv/ptrf_checker.sv
// ---------------------------------------------------------------------------
// ptrf_checker
// Port-level checks of the page-turn row fold, bound to the top level.
// ---------------------------------------------------------------------------
module ptrf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [10:0] out_column
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its column
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_column))
		else $error("result column changed while stalled");

	// one transaction at a time: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted back to back");

	// a new result is loaded only from a busy cycle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a transaction in flight");

endmodule

bind page_turn_row_fold_core ptrf_checker u_ptrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel_stream.valid),
	.in_ready  (pixel_stream.ready),
	.out_valid (result_stream.valid),
	.out_ready (result_stream.ready),
	.out_column(result_stream.out_column)
);

### dv/tb_page_turn_row_fold_core.sv
// ---------------------------------------------------------------------------
// tb_page_turn_row_fold_core
// Self-checking bench for the page-turn row fold. Pixels go in through a
// randomly paced driver; an in-bench line store model predicts each processed
// pixel of the previous row, and a randomly stalling monitor compares every
// result against the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module tb_page_turn_row_fold_core import ptrf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          MAXW        = MAX_WIDTH;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned SETTLE      = 10;
	localparam int unsigned RANDOM_GOAL = 1250;
	localparam int unsigned STEP_LEGAL  = 4697620;
	localparam int unsigned STEP_FULL   = 8388607;
	localparam longint unsigned SHADE_AT_FOLD = 64'd8724152;

	// floor(75*sin(i*pi/30)) across the highlight band
	localparam logic [7:0] SHEEN [0:23] = '{
		8'd0, 8'd7, 8'd15, 8'd23, 8'd30, 8'd37, 8'd44, 8'd50,
		8'd55, 8'd60, 8'd64, 8'd68, 8'd71, 8'd73, 8'd74, 8'd75,
		8'd74, 8'd73, 8'd71, 8'd68, 8'd64, 8'd60, 8'd55, 8'd50
	};

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [10:0] column;
		logic        flush;
	} pixel_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [10:0] column;
	} folded_t;

	typedef struct {
		pixel_t  px;
		bit      yields;
		folded_t res;
		bit      drain_first;
	} queued_pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ptrf_pixel_if  pix_if();
	ptrf_result_if res_if();

	page_turn_row_fold_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_stream (pix_if),
		.result_stream(res_if),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// line store model: ping-pong banks plus a written map per entry
	logic [23:0]       line_mem [2*MAXW];
	bit                line_written [2*MAXW];
	bit                wr_bank;
	bit                row_primed;
	logic [FW_W-1:0]   fw_reg;
	logic [CUT_W-1:0]  cut_reg;
	logic [STEP_W-1:0] step_reg;

	queued_pixel_t pixel_backlog [$];
	folded_t       fold_expected [$];
	queued_pixel_t in_flight;

	int unsigned fail_cnt;
	int unsigned accepted_cnt;
	int unsigned checked_cnt;
	int unsigned settings_cnt;
	int unsigned cycle_cnt;
	int unsigned gap_left;
	int unsigned stall_left;
	bit          calm_src;
	bit          calm_snk;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned eff_width();
		if (fw_reg < 1) return 1;
		if (fw_reg > MAXW) return MAXW;
		return fw_reg;
	endfunction

	// store address of the previous-row pixel shown at column col
	function automatic int unsigned prev_addr(int unsigned col);
		int unsigned w;
		int unsigned src;
		w = eff_width();
		src = (cut_reg < w && col >= cut_reg) ? w - 1 - (col - cut_reg) : col;
		return (wr_bank ? 0 : MAXW) + src;
	endfunction

	function automatic bit row_complete();
		int unsigned base;
		base = wr_bank ? MAXW : 0;
		for (int unsigned c = 0; c < eff_width(); c++)
			if (!line_written[base + c]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [7:0] dim(logic [7:0] c, logic [23:0] shade);
		logic [31:0] prod;
		prod = c * shade;
		return prod[31:24];
	endfunction

	function automatic logic [7:0] brighten(logic [7:0] c, logic [7:0] h);
		logic [8:0] s;
		s = c + h;
		return (s > 9'd255) ? 8'd255 : s[7:0];
	endfunction

	// one pixel through the fold: result for the previous row, then store update
	function automatic bit fold_pixel(input pixel_t p, output folded_t q);
		int unsigned     w;
		int unsigned     col;
		int unsigned     k;
		longint unsigned drop;
		logic [23:0]     shade;
		logic [23:0]     prev;
		logic [7:0]      h;
		bit              yields;
		w = eff_width();
		col = p.column;
		q = '0;
		yields = 1'b0;
		if (col >= w) return 1'b0;
		if (row_primed) begin
			prev = line_mem[prev_addr(col)];
			if (cut_reg < w && col >= cut_reg) begin
				k = col - cut_reg;
				drop = k;
				drop = drop * step_reg;
				shade = (drop >= SHADE_AT_FOLD) ? 24'd0 : 24'(SHADE_AT_FOLD - drop);
				q.red   = dim(prev[23:16], shade);
				q.green = dim(prev[15:8], shade);
				q.blue  = dim(prev[7:0], shade);
			end else begin
				q.red   = prev[23:16];
				q.green = prev[15:8];
				q.blue  = prev[7:0];
				if (cut_reg < w && col + BAND_WIDTH >= cut_reg) begin
					h = SHEEN[col + BAND_WIDTH - cut_reg];
					q.red   = brighten(q.red, h);
					q.green = brighten(q.green, h);
					q.blue  = brighten(q.blue, h);
				end
			end
			q.column = p.column;
			yields = 1'b1;
		end
		if (p.flush) begin
			if (col == w - 1) row_primed = 1'b0;
		end else begin
			line_mem[(wr_bank ? MAXW : 0) + col] = {p.red, p.green, p.blue};
			line_written[(wr_bank ? MAXW : 0) + col] = 1'b1;
			if (col == w - 1) begin
				wr_bank = ~wr_bank;
				row_primed = 1'b1;
			end
		end
		return yields;
	endfunction

	// queue a pixel with its prediction; never reads a store entry not yet written
	function automatic bit queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			int unsigned col, bit fl);
		queued_pixel_t item;
		if (col < eff_width() && row_primed && !line_written[prev_addr(col)]) return 1'b0;
		item.px = '{red: r, green: g, blue: b, column: 11'(col), flush: fl};
		item.yields = fold_pixel(item.px, item.res);
		item.drain_first = ($urandom_range(0, 249) == 0);
		pixel_backlog.push_back(item);
		return col < eff_width();
	endfunction

	function automatic logic [7:0] chan();
		int unsigned k;
		k = $urandom_range(0, 7);
		if (k == 0) return 8'd0;
		if (k == 1) return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	// block idle: nothing queued, nothing driven, nothing outstanding
	task automatic wait_drained();
		@(negedge clk);
		while (pixel_backlog.size() != 0 || pix_if.valid || fold_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic put_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic program_fold(int unsigned fw, int unsigned cut, int unsigned step);
		put_reg(CFG_FRAME_WIDTH, CFG_W'(fw));
		put_reg(CFG_CUT_COLUMN, CFG_W'(cut));
		put_reg(CFG_SHADE_STEP, CFG_W'(step));
		fw_reg   = FW_W'(fw);
		cut_reg  = CUT_W'(cut);
		step_reg = STEP_W'(step);
		settings_cnt++;
	endtask

	// two stored rows and a flushed row over a column subset that keeps mirrors intact
	task automatic sparse_pass();
		bit          pick [MAXW];
		int unsigned w;
		int unsigned lo;
		int unsigned hi;
		w = eff_width();
		for (int unsigned c = 0; c < MAXW; c++)
			pick[c] = (c < w) && (c < 16 || c + 16 >= w);
		if (cut_reg < w) begin
			lo = (cut_reg >= BAND_WIDTH) ? cut_reg - BAND_WIDTH : 0;
			hi = (cut_reg + 15 < w) ? cut_reg + 15 : w - 1;
			for (int unsigned c = lo; c <= hi; c++) pick[c] = 1'b1;
		end
		for (int unsigned rnd = 0; rnd < 3; rnd++)
			for (int unsigned c = 0; c < w; c++)
				if (pick[c]) void'(queue_pixel(chan(), chan(), chan(), c, rnd == 2));
		wait_drained();
	endtask

	// one random register setting followed by rows, drains and stray pixels
	task automatic random_phase(int unsigned n, output int unsigned done);
		int unsigned w;
		int unsigned cut;
		int unsigned step;
		int unsigned k;
		int unsigned c;
		bit          fl;
		k = $urandom_range(0, 9);
		w = (k < 7) ? $urandom_range(2, 24) : (k < 9) ? $urandom_range(25, 120)
			: $urandom_range(121, 300);
		k = $urandom_range(0, 9);
		case (k)
			0, 1, 2, 3: cut = $urandom_range(0, w - 1);
			4:          cut = 0;
			5:          cut = w - 1;
			6:          cut = $urandom_range(w, w + 30);
			7:          cut = MAXW;
			8:          cut = 4095;
			default:    cut = $urandom_range(0, 4095);
		endcase
		k = $urandom_range(0, 9);
		if (k < 4 && cut < w) step = STEP_LEGAL / (w - cut) + $urandom_range(0, 3);
		else if (k < 6) step = $urandom_range(0, STEP_LEGAL);
		else if (k < 8) step = $urandom_range(0, STEP_FULL);
		else if (k == 8) step = STEP_LEGAL;
		else step = 0;
		program_fold(w, cut, step);
		done = 0;
		while (done < n) begin
			k = $urandom_range(0, 99);
			if (k < 65) begin
				for (c = 0; c < w; c++) done += queue_pixel(chan(), chan(), chan(), c, 1'b0);
			end else if (k < 78) begin
				for (c = 0; c < w; c++) done += queue_pixel(chan(), chan(), chan(), c, 1'b1);
			end else begin
				repeat ($urandom_range(1, 10)) begin
					c = ($urandom_range(0, 99) < 12) ? $urandom_range(w, 2047)
						: $urandom_range(0, w - 1);
					fl = ($urandom_range(0, 3) == 0);
					// a stored row may only close once every column of it is written
					if (!fl && c == w - 1 && !row_complete()) fl = 1'b1;
					done += queue_pixel(chan(), chan(), chan(), c, fl);
				end
			end
		end
		if (row_primed) void'(queue_pixel(chan(), chan(), chan(), w - 1, 1'b1));
		wait_drained();
	endtask

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_if.valid    <= 1'b0;
			pix_if.red_in   <= '0;
			pix_if.green_in <= '0;
			pix_if.blue_in  <= '0;
			pix_if.column   <= '0;
			pix_if.flush    <= 1'b0;
			gap_left = 0;
		end else begin
			if (pix_if.valid && pix_if.ready) begin
				accepted_cnt++;
				if (in_flight.yields) fold_expected.push_back(in_flight.res);
			end
			if (!pix_if.valid || pix_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					pix_if.valid <= 1'b0;
				end else if (pixel_backlog.size() != 0 && (!pixel_backlog[0].drain_first ||
						(fold_expected.size() == 0 && !(res_if.valid && res_if.ready)))) begin
					in_flight = pixel_backlog.pop_front();
					pix_if.valid    <= 1'b1;
					pix_if.red_in   <= in_flight.px.red;
					pix_if.green_in <= in_flight.px.green;
					pix_if.blue_in  <= in_flight.px.blue;
					pix_if.column   <= in_flight.px.column;
					pix_if.flush    <= in_flight.px.flush;
					if ($urandom_range(0, 39) == 0) calm_src = ~calm_src;
					gap_left = calm_src ? 0 : $urandom_range(0, 3);
				end else begin
					pix_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		folded_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				checked_cnt++;
				if (fold_expected.size() == 0) begin
					$error("unexpected result at column %0d", res_if.out_column);
					fail_cnt++;
				end else begin
					want = fold_expected.pop_front();
					if (res_if.red_out !== want.red) begin
						$error("red_out: expected %0d, got %0d", want.red, res_if.red_out);
						fail_cnt++;
					end
					if (res_if.green_out !== want.green) begin
						$error("green_out: expected %0d, got %0d", want.green, res_if.green_out);
						fail_cnt++;
					end
					if (res_if.blue_out !== want.blue) begin
						$error("blue_out: expected %0d, got %0d", want.blue, res_if.blue_out);
						fail_cnt++;
					end
					if (res_if.out_column !== want.column) begin
						$error("out_column: expected %0d, got %0d", want.column,
							res_if.out_column);
						fail_cnt++;
					end
				end
				if ($urandom_range(0, 39) == 0) calm_snk = ~calm_snk;
				stall_left = calm_snk ? 0 : $urandom_range(0, 3);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			res_if.ready <= (stall_left == 0);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				fold_expected.size());
			$display("[page_turn_row_fold_core] ERROR");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		int unsigned random_done;
		int unsigned got;
		cfg_we          = 1'b0;
		cfg_index       = CFG_FRAME_WIDTH;
		cfg_data        = '0;
		pix_if.valid    = 1'b0;
		pix_if.red_in   = '0;
		pix_if.green_in = '0;
		pix_if.blue_in  = '0;
		pix_if.column   = '0;
		pix_if.flush    = 1'b0;
		res_if.ready    = 1'b0;
		wr_bank    = 1'b0;
		row_primed = 1'b0;
		fw_reg     = FW_RESET;
		cut_reg    = CUT_RESET;
		step_reg   = STEP_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values: width 640, no fold
		sparse_pass();

		// narrow row: band highlight with saturation, both shade regions, strays
		program_fold(4, 2, STEP_LEGAL);
		void'(queue_pixel(8'd255, 8'd255, 8'd255, 0, 1'b0));
		void'(queue_pixel(8'd0, 8'd0, 8'd0, 1, 1'b0));
		void'(queue_pixel(8'd255, 8'd0, 8'd128, 2, 1'b0));
		void'(queue_pixel(8'd1, 8'd2, 8'd3, 3, 1'b0));
		void'(queue_pixel(8'd10, 8'd20, 8'd30, 4, 1'b0));
		void'(queue_pixel(8'd255, 8'd255, 8'd255, 2047, 1'b1));
		void'(queue_pixel(8'd200, 8'd100, 8'd0, 0, 1'b0));
		void'(queue_pixel(8'd255, 8'd255, 8'd255, 1, 1'b0));
		void'(queue_pixel(8'd0, 8'd255, 8'd0, 2, 1'b0));
		void'(queue_pixel(8'd255, 8'd255, 8'd255, 3, 1'b0));
		for (int unsigned c = 0; c < 4; c++) void'(queue_pixel(8'd0, 8'd0, 8'd0, c, 1'b1));
		void'(queue_pixel(8'd9, 8'd9, 8'd9, 1, 1'b1));
		wait_drained();

		// width register zero acts as one column, fold from column zero
		program_fold(0, 0, STEP_FULL);
		repeat (3) void'(queue_pixel(chan(), chan(), chan(), 0, 1'b0));
		void'(queue_pixel(8'd7, 8'd7, 8'd7, 5, 1'b0));
		void'(queue_pixel(8'd0, 8'd0, 8'd0, 0, 1'b1));
		wait_drained();

		// widest rows: oversized width register, then exact maximum
		program_fold(4095, 2000, STEP_FULL);
		sparse_pass();
		program_fold(MAXW, 1030, STEP_LEGAL / (MAXW - 1030));
		sparse_pass();
		program_fold(MAXW, 4095, 0);
		sparse_pass();

		random_done = 0;
		while (random_done < RANDOM_GOAL) begin
			random_phase($urandom_range(60, 220), got);
			random_done += got;
		end

		wait_drained();
		$display("%0d pixels accepted, %0d processed pixels checked, %0d register settings",
			accepted_cnt, checked_cnt, settings_cnt);
		$display("covered fold, highlight band, pass-through, flush drains and stray columns");
		if (fail_cnt == 0) begin
			$display("[page_turn_row_fold_core] OK");
		end else begin
			$display("[page_turn_row_fold_core] ERROR");
		end
		$finish;
	end

endmodule
